[hdl/tbfe_pkg.sv]
// shared constants, codes and control structs of the three-band fir equalizer
package tbfe_pkg;

   // filter geometry
   localparam int TAPS     = 81;
   localparam int CHANNELS = 2;
   localparam int NBANKS   = 3;

   // field widths
   localparam int CH_BITS   = 1;
   localparam int BANK_BITS = 2;
   localparam int TAP_FW    = 7;
   localparam int SAMPLE_W  = 16;
   localparam int COEF_W    = 17;
   localparam int OUT_W     = 16;

   // arithmetic widths
   localparam int PROD_W  = SAMPLE_W + COEF_W;
   localparam int ACC_W   = 40;
   localparam int OUT_LSB = 16;

   // memory geometry: entries addressed as {channel, index} and {bank, tap}
   localparam int TAP_BITS   = $clog2(TAPS);
   localparam int TAP_SPAN   = 1 << TAP_BITS;
   localparam int HIST_ABITS = CH_BITS + TAP_BITS;
   localparam int COEF_ABITS = BANK_BITS + TAP_BITS;
   localparam int HIST_DEPTH = 1 << HIST_ABITS;
   localparam int COEF_DEPTH = NBANKS * TAP_SPAN;
   localparam int CLR_LEN    = (COEF_DEPTH > HIST_DEPTH) ? COEF_DEPTH : HIST_DEPTH;
   localparam int CLR_BITS   = $clog2(CLR_LEN);

   // stream packing
   localparam int SMP_LSB  = 0;
   localparam int BANK_LSB = SMP_LSB + SAMPLE_W;
   localparam int TAP_LSB  = BANK_LSB + BANK_BITS;
   localparam int COEF_LSB = TAP_LSB + TAP_FW;
   localparam int REQ_BITS = COEF_LSB + COEF_W;
   localparam int REQ_DW   = ((REQ_BITS + 7) / 8) * 8;
   localparam int REQ_UW   = 2;
   localparam int RSP_DW   = OUT_W;
   localparam int RSP_UW   = 1;

   // configuration port
   localparam int CSR_IW = 2;
   localparam int CSR_DW = 1;
   localparam logic [CSR_IW-1:0] CSR_BYPASS    = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_LOWPASS   = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_BANDPASS  = 2'd2;
   localparam logic [CSR_IW-1:0] CSR_HIGHPASS  = 2'd3;

   // item kinds
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_COEF   = 1'b1;

   // sequencer to memory block
   typedef struct packed {
      logic                   hist_we;
      logic [HIST_ABITS-1:0]  hist_waddr;
      logic [SAMPLE_W-1:0]    hist_wdata;
      logic [HIST_ABITS-1:0]  hist_raddr;
      logic                   coef_we;
      logic [COEF_ABITS-1:0]  coef_waddr;
      logic [COEF_W-1:0]      coef_wdata;
      logic [COEF_ABITS-1:0]  coef_raddr;
   } store_ctl_type;

   // sequencer to multiply-accumulate unit
   typedef struct packed {
      logic clear;
      logic valid;
      logic en;
   } mac_ctl_type;

endpackage

[hdl/tbfe_mac.sv]
// shared multiply and 40-bit saturating accumulate unit
module tbfe_mac (
   input  logic                                clock,
   input  logic                                reset,
   input  tbfe_pkg::mac_ctl_type               ctl,
   input  logic signed [tbfe_pkg::SAMPLE_W-1:0] hist,
   input  logic signed [tbfe_pkg::COEF_W-1:0]   coef,
   output logic [tbfe_pkg::ACC_W-1:0]          acc,
   output logic                                busy
);
   import tbfe_pkg::*;

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     prod_v_ff;
   logic [ACC_W-1:0]         acc_ff, acc_in;
   logic [ACC_W:0]           sum;

   // product stage, disabled banks contribute zero
   always_comb begin
      prod_in = ctl.en ? (PROD_W'(hist) * PROD_W'(coef)) : '0;
   end

   // add with one guard bit, clamp on overflow
   always_comb begin
      sum = {acc_ff[ACC_W-1], acc_ff} + (ACC_W + 1)'(prod_ff);
      if (sum[ACC_W] != sum[ACC_W-1]) begin
         acc_in = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         acc_in = sum[ACC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_v_ff <= 1'b0;
         acc_ff    <= '0;
      end else begin
         prod_v_ff <= ctl.valid;
         if (ctl.clear) begin
            acc_ff <= '0;
         end else if (prod_v_ff) begin
            acc_ff <= acc_in;
         end
      end
   end

   assign acc  = acc_ff;
   assign busy = prod_v_ff;

endmodule

[hdl/tbfe_store.sv]
// history and coefficient memories with the clearing sweep after reset
module tbfe_store (
   input  logic                            clock,
   input  logic                            reset,
   input  tbfe_pkg::store_ctl_type         ctl,
   output logic [tbfe_pkg::SAMPLE_W-1:0]   hist_q,
   output logic [tbfe_pkg::COEF_W-1:0]     coef_q,
   output logic                            ready
);
   import tbfe_pkg::*;

   logic [SAMPLE_W-1:0]   hist_ram_ff [HIST_DEPTH];
   logic [COEF_W-1:0]     coef_ram_ff [COEF_DEPTH];
   logic [SAMPLE_W-1:0]   hist_q_ff;
   logic [COEF_W-1:0]     coef_q_ff;

   logic [CLR_BITS-1:0]   clr_cnt_ff, clr_cnt_in;
   logic                  clr_busy_ff, clr_busy_in;

   logic                  hist_we;
   logic [HIST_ABITS-1:0] hist_waddr;
   logic [SAMPLE_W-1:0]   hist_wdata;
   logic                  coef_we;
   logic [COEF_ABITS-1:0] coef_waddr;
   logic [COEF_W-1:0]     coef_wdata;

   // sweep counter
   always_comb begin
      clr_cnt_in  = clr_cnt_ff;
      clr_busy_in = clr_busy_ff;
      if (clr_busy_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == CLR_BITS'(CLR_LEN - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff  <= '0;
         clr_busy_ff <= 1'b1;
      end else begin
         clr_cnt_ff  <= clr_cnt_in;
         clr_busy_ff <= clr_busy_in;
      end
   end

   // write port select: sweep zeros or sequencer writes
   always_comb begin
      if (clr_busy_ff) begin
         hist_we    = ({1'b0, clr_cnt_ff} < (CLR_BITS + 1)'(HIST_DEPTH));
         hist_waddr = clr_cnt_ff[HIST_ABITS-1:0];
         hist_wdata = '0;
         coef_we    = ({1'b0, clr_cnt_ff} < (CLR_BITS + 1)'(COEF_DEPTH));
         coef_waddr = clr_cnt_ff[COEF_ABITS-1:0];
         coef_wdata = '0;
      end else begin
         hist_we    = ctl.hist_we;
         hist_waddr = ctl.hist_waddr;
         hist_wdata = ctl.hist_wdata;
         coef_we    = ctl.coef_we;
         coef_waddr = ctl.coef_waddr;
         coef_wdata = ctl.coef_wdata;
      end
   end

   // history memory
   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_ram_ff[hist_waddr] <= hist_wdata;
      end
      hist_q_ff <= hist_ram_ff[ctl.hist_raddr];
   end

   // coefficient memory
   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_ram_ff[coef_waddr] <= coef_wdata;
      end
      coef_q_ff <= coef_ram_ff[ctl.coef_raddr];
   end

   assign hist_q = hist_q_ff;
   assign coef_q = coef_q_ff;
   assign ready  = !clr_busy_ff;

endmodule

[hdl/three_band_fir_equalizer_top.sv]
// three-band fir equalizer: sequencer, config registers and result register
// path: a coefficient beat is written from idle; a bypassed sample goes via finish to
//   the result register; a filtered sample via mac, drain and finish, the one shared
//   multiply-accumulate unit taking each tap of all 3 banks, one product per cycle
// throughput: a coefficient beat every cycle in idle; req_tready is low from a sample's
//   acceptance until its result is registered, which waits while rsp stalls
// reset: synchronous, active high; clears the config registers, then a sweep zeroes
//   both memories before req_tready first rises
module three_band_fir_equalizer_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // sample[15:0] bank[17:16] tap[24:18] coefficient[41:25], zero above
   input  logic [tbfe_pkg::REQ_DW-1:0]   req_tdata,
   // operation[0] channel[1]
   input  logic [tbfe_pkg::REQ_UW-1:0]   req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // filtered or bypassed sample[15:0]
   output logic [tbfe_pkg::RSP_DW-1:0]   rsp_tdata,
   // out_channel[0]
   output logic [tbfe_pkg::RSP_UW-1:0]   rsp_tuser,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [tbfe_pkg::CSR_IW-1:0]   csr_index,
   input  logic [tbfe_pkg::CSR_DW-1:0]   csr_wdata
);
   import tbfe_pkg::*;

   typedef enum logic [4:0] {
      ST_CLEAR  = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_MAC    = 5'b00100,
      ST_DRAIN  = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type             state_ff, state_in;

   // config registers
   logic                  bypass_ff, lowpass_ff, bandpass_ff, highpass_ff;

   // per-channel ring pointers to the newest sample
   logic [TAP_BITS-1:0]   ptr_ff [CHANNELS];
   logic [TAP_BITS-1:0]   ptr_in [CHANNELS];

   // item context
   logic [CH_BITS-1:0]    ch_ff, ch_in;
   logic [SAMPLE_W-1:0]   sample_ff, sample_in;
   logic                  pass_ff, pass_in;
   logic [TAP_BITS-1:0]   hidx_ff, hidx_in;
   logic [TAP_BITS-1:0]   ctap_ff, ctap_in;
   logic [BANK_BITS-1:0]  bank_ff, bank_in;

   // read pipeline tracking
   logic                  rd_valid_ff, rd_en_ff;
   logic                  issue;

   // result register
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [OUT_W-1:0]      rsp_data_ff, rsp_data_in;
   logic [CH_BITS-1:0]    rsp_ch_ff, rsp_ch_in;

   // input fields
   logic                  in_op;
   logic [CH_BITS-1:0]    in_ch;
   logic [SAMPLE_W-1:0]   in_sample;
   logic [BANK_BITS-1:0]  in_bank;
   logic [TAP_FW-1:0]     in_tap;
   logic [COEF_W-1:0]     in_coef;
   logic                  req_accept;
   logic                  ch_ok, coef_ok;
   logic [TAP_BITS-1:0]   ptr_cur, ptr_next, hidx_dec;
   logic [NBANKS-1:0]     en_vec;

   store_ctl_type         sctl;
   mac_ctl_type           mctl;
   logic [SAMPLE_W-1:0]   hist_q;
   logic [COEF_W-1:0]     coef_q;
   logic                  store_ready;
   logic [ACC_W-1:0]      acc;
   logic                  mac_busy;

   // unpack the request beat
   assign in_op      = req_tuser[0];
   assign in_ch      = req_tuser[1];
   assign in_sample  = req_tdata[SMP_LSB  +: SAMPLE_W];
   assign in_bank    = req_tdata[BANK_LSB +: BANK_BITS];
   assign in_tap     = req_tdata[TAP_LSB  +: TAP_FW];
   assign in_coef    = req_tdata[COEF_LSB +: COEF_W];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign ch_ok      = (4'(in_ch) < 4'(CHANNELS));
   assign coef_ok    = (in_bank < BANK_BITS'(NBANKS)) && (9'(in_tap) < 9'(TAPS));
   assign en_vec     = {highpass_ff, bandpass_ff, lowpass_ff};

   // ring pointer arithmetic
   assign ptr_cur  = ptr_ff[in_ch];
   assign ptr_next = (ptr_cur == TAP_BITS'(TAPS - 1)) ? '0 : ptr_cur + 1'b1;
   assign hidx_dec = (hidx_ff == '0) ? TAP_BITS'(TAPS - 1) : hidx_ff - 1'b1;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      ptr_in        = ptr_ff;
      ch_in         = ch_ff;
      sample_in     = sample_ff;
      pass_in       = pass_ff;
      hidx_in       = hidx_ff;
      ctap_in       = ctap_ff;
      bank_in       = bank_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_ch_in     = rsp_ch_ff;
      issue         = 1'b0;
      mctl.clear    = 1'b0;
      mctl.valid    = rd_valid_ff;
      mctl.en       = rd_en_ff;

      sctl            = '0;
      sctl.hist_raddr = {ch_ff, hidx_ff};
      sctl.coef_raddr = {bank_ff, ctap_ff};

      case (state_ff)
         ST_CLEAR: begin
            if (store_ready) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               if (in_op == OP_COEF) begin
                  sctl.coef_we    = coef_ok;
                  sctl.coef_waddr = {in_bank, TAP_BITS'(in_tap)};
                  sctl.coef_wdata = in_coef;
               end else if (ch_ok) begin
                  sctl.hist_we    = 1'b1;
                  sctl.hist_waddr = {in_ch, ptr_next};
                  sctl.hist_wdata = in_sample;
                  ptr_in[in_ch]   = ptr_next;
                  ch_in           = in_ch;
                  sample_in       = in_sample;
                  pass_in         = bypass_ff;
                  hidx_in         = ptr_next;
                  ctap_in         = TAP_BITS'(TAPS - 1);
                  bank_in         = '0;
                  mctl.clear      = 1'b1;
                  state_in        = bypass_ff ? ST_FINISH : ST_MAC;
               end
            end
         end
         ST_MAC: begin
            issue = 1'b1;
            if (bank_ff == BANK_BITS'(NBANKS - 1)) begin
               bank_in = '0;
               ctap_in = ctap_ff - 1'b1;
               hidx_in = hidx_dec;
               if (ctap_ff == '0) begin
                  state_in = ST_DRAIN;
               end
            end else begin
               bank_in = bank_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!rd_valid_ff && !mac_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_ch_in     = ch_ff;
               rsp_data_in   = pass_ff ? sample_ff : acc[OUT_LSB +: OUT_W];
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         rsp_tvalid_ff <= 1'b0;
         rd_valid_ff   <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            ptr_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         rd_valid_ff   <= issue;
         ptr_ff        <= ptr_in;
      end
   end

   // item context and result payload
   always_ff @(posedge clock) begin
      ch_ff       <= ch_in;
      sample_ff   <= sample_in;
      pass_ff     <= pass_in;
      hidx_ff     <= hidx_in;
      ctap_ff     <= ctap_in;
      bank_ff     <= bank_in;
      rd_en_ff    <= en_vec[bank_ff];
      rsp_data_ff <= rsp_data_in;
      rsp_ch_ff   <= rsp_ch_in;
   end

   // config registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bypass_ff   <= 1'b0;
         lowpass_ff  <= 1'b0;
         bandpass_ff <= 1'b0;
         highpass_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BYPASS:   bypass_ff   <= csr_wdata[0];
            CSR_LOWPASS:  lowpass_ff  <= csr_wdata[0];
            CSR_BANDPASS: bandpass_ff <= csr_wdata[0];
            CSR_HIGHPASS: highpass_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   tbfe_store u_store (
      .clock  (clock),
      .reset  (reset),
      .ctl    (sctl),
      .hist_q (hist_q),
      .coef_q (coef_q),
      .ready  (store_ready)
   );

   tbfe_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctl   (mctl),
      .hist  (hist_q),
      .coef  (coef_q),
      .acc   (acc),
      .busy  (mac_busy)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_ch_ff;

   // no beat taken while the memories are still being swept
   a_no_accept_in_sweep: assert property (@(posedge clock) disable iff (reset)
      !store_ready |-> !req_tready)
      else $error("request taken during memory sweep");

   // a new result only comes out of the finish step
   a_result_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result raised outside finish");

   // the accumulator has settled before a result is taken from it
   a_drained_at_finish: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |-> (!rd_valid_ff && !mac_busy))
      else $error("mac pipeline busy at finish");

   // a filtered sample starts the tap sweep at the last coefficient of bank zero
   a_sweep_start: assert property (@(posedge clock) disable iff (reset)
      (req_accept && in_op == OP_SAMPLE && ch_ok && !bypass_ff)
      |=> (state_ff == ST_MAC && bank_ff == '0 && ctap_ff == TAP_BITS'(TAPS - 1)))
      else $error("tap sweep did not start correctly");

   // a coefficient beat leaves the sequencer in idle
   a_coef_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (req_accept && in_op == OP_COEF) |=> (state_ff == ST_IDLE))
      else $error("coefficient beat left idle");

endmodule
